@@ rtl/c2s_pkg.sv @@
// ----------------------------------------------------------------------------
// c2s_pkg
// Shared constants and types for the cartesian to spherical unit: angle
// accumulator format, CORDIC arctangent table and gain.
// ----------------------------------------------------------------------------
package c2s_pkg;

  // Angle accumulators hold degrees with ACC_FRAC fraction bits
  localparam int ACC_FRAC = 24;
  // Coordinates enter the CORDIC datapath scaled up by 2^GUARD
  localparam int GUARD    = 24;
  // Signed accumulator width: covers -100 to +360 degrees with margin
  localparam int ACC_W    = 34;

  // CORDIC gain applied to z before the second pass, Q1.30
  localparam int GAIN_W = 31;
  localparam logic [GAIN_W-1:0] GAIN_Q30 = 31'd1768195363;

  localparam logic signed [ACC_W-1:0] ANGLE_180 = ACC_W'(180) << ACC_FRAC;
  localparam logic signed [ACC_W-1:0] ANGLE_360 = ACC_W'(360) << ACC_FRAC;

  // atan(2^-i) in degrees, ACC_FRAC fraction bits
  localparam logic [ACC_W-1:0] ATAN_DEG [32] = '{
    34'd754974720, 34'd445687602, 34'd235489088, 34'd119537938,
    34'd60000934,  34'd30029717,  34'd15018523,  34'd7509720,
    34'd3754917,   34'd1877466,   34'd938734,    34'd469367,
    34'd234684,    34'd117342,    34'd58671,     34'd29335,
    34'd14668,     34'd7334,      34'd3667,      34'd1833,
    34'd917,       34'd458,       34'd229,       34'd115,
    34'd57,        34'd29,        34'd14,        34'd7,
    34'd4,         34'd2,         34'd1,         34'd0
  };

  // Special-case marks that travel with each point
  typedef struct packed {
    logic xy_zero;   // x and y both zero: azimuth forced to zero
    logic all_zero;  // zero vector: every result forced to zero
  } c2s_flags_t;

endpackage

@@ rtl/cartesian_to_spherical_unit.sv @@
// ----------------------------------------------------------------------------
// cartesian_to_spherical_unit
// Converts a signed point (x, y, z) into rounded radius, azimuth in [0, 360)
// degrees and polar angle in [0, 180] degrees, angles in 1/2^ANGLE_FRAC_BITS
// degree. Two chained CORDIC vectoring pipelines produce the angles; a
// pipelined square root runs beside them for the radius.
//
//   channel   ports                              handshake
//   --------  ---------------------------------  ---------------------------
//   point     coord_x, coord_y, coord_z          start, taken when busy low
//   result    radius, azimuth, polar             done, one-cycle strobe
//
// One point enters per clock; busy never rises. Each result appears after
// the longer of the angle and radius paths, at the defaults the two CORDIC
// passes in series; the shorter path is padded to match.
// Reset clears only the valid bits; the payload pipeline needs no clearing.
// The receiver cannot stall, so no beat is ever held back.
// ----------------------------------------------------------------------------
module cartesian_to_spherical_unit #(
  parameter int COORD_BITS      = 16,
  parameter int ANGLE_FRAC_BITS = 8,
  parameter int CORDIC_STAGES   = 18
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [COORD_BITS-1:0]    coord_x,
  input  logic signed [COORD_BITS-1:0]    coord_y,
  input  logic signed [COORD_BITS-1:0]    coord_z,
  output logic                            done,
  output logic        [COORD_BITS-1:0]    radius,
  output logic        [ANGLE_FRAC_BITS+8:0] azimuth,
  output logic        [ANGLE_FRAC_BITS+7:0] polar
);

  localparam int C      = COORD_BITS;
  localparam int N      = CORDIC_STAGES;
  localparam int ACC_W  = c2s_pkg::ACC_W;
  // Azimuth spans 360 degrees, polar 180 degrees
  localparam int AZ_W   = ANGLE_FRAC_BITS + 9;
  localparam int PO_W   = ANGLE_FRAC_BITS + 8;
  localparam int FLAG_W = $bits(c2s_pkg::c2s_flags_t);

  // Datapath widths: pass one holds x, y scaled by 2^GUARD with gain growth,
  // pass two also carries the gain-scaled z
  localparam int DW1    = C + c2s_pkg::GUARD + 2;
  localparam int DW2    = DW1 + 1;
  localparam int ZP_W   = C + c2s_pkg::GAIN_W;
  localparam int ZK_W   = ZP_W - 6;
  localparam int TAG1_W = C + FLAG_W;
  localparam int TAG2_W = AZ_W + FLAG_W;

  // Angle rounding
  localparam int SH = c2s_pkg::ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic [ACC_W-1:0] HALF    = ACC_W'(1) << (SH - 1);
  localparam logic [ACC_W-1:0] AZ_FULL = ACC_W'(360) << ANGLE_FRAC_BITS;

  // Latency of each path and the padding that aligns them
  localparam int ANG_LAT = 2 * N + 5;
  localparam int SQ_LAT  = C + 3;
  localparam int LAT     = (ANG_LAT > SQ_LAT) ? ANG_LAT : SQ_LAT;
  localparam int RAD_DLY = LAT - SQ_LAT;
  localparam int ANG_DLY = LAT - ANG_LAT;

  c2s_pkg::c2s_flags_t in_flags;

  logic                      c1_done;
  logic signed [DW1-1:0]     c1_mag;
  logic signed [ACC_W-1:0]   c1_angle;
  logic        [TAG1_W-1:0]  c1_tag;
  logic signed [C-1:0]       c1_z;
  c2s_pkg::c2s_flags_t       c1_flags;

  logic signed [ZP_W-1:0]    z_ext, gain_ext;

  logic                      m1_vld;
  logic signed [ZP_W-1:0]    m1_zprod;
  logic        [ACC_W-1:0]   m1_az_sum;
  logic signed [DW1-1:0]     m1_mag;
  c2s_pkg::c2s_flags_t       m1_flags;

  logic        [ACC_W-1:0]   az_rnd, az_wrap;
  logic signed [ZP_W-1:0]    zk_sum;

  logic                      m2_vld;
  logic signed [ZK_W-1:0]    m2_zk;
  logic        [AZ_W-1:0]    m2_az;
  logic signed [DW1-1:0]     m2_mag;
  c2s_pkg::c2s_flags_t       m2_flags;

  logic                      c2_done;
  logic signed [DW2-1:0]     c2_mag;
  logic signed [ACC_W-1:0]   c2_angle;
  logic        [TAG2_W-1:0]  c2_tag;
  c2s_pkg::c2s_flags_t       c2_flags;

  logic signed [ACC_W-1:0]   po_clamp;
  logic        [ACC_W-1:0]   po_rnd;

  logic                      f_vld;
  logic        [AZ_W-1:0]    f_az;
  logic        [PO_W-1:0]    f_po;

  logic        [C-1:0]       rad_raw;

  // Fully pipelined: always ready for a new beat
  assign busy = 1'b0;

  // Mark the special cases at entry
  assign in_flags.xy_zero  = (coord_x == '0) && (coord_y == '0);
  assign in_flags.all_zero = (coord_x == '0) && (coord_y == '0) && (coord_z == '0);

  // Pass one: azimuth and xy magnitude
  c2s_cordic #(
    .STAGES (N),
    .DATA_W (DW1),
    .TAG_W  (TAG1_W)
  ) u_pass_xy (
    .clk      (clk),
    .rst      (rst),
    .load     (start),
    .a_init   ({{2{coord_x[C-1]}}, coord_x, {c2s_pkg::GUARD{1'b0}}}),
    .b_init   ({{2{coord_y[C-1]}}, coord_y, {c2s_pkg::GUARD{1'b0}}}),
    .tag_init ({coord_z, in_flags}),
    .done     (c1_done),
    .mag      (c1_mag),
    .angle    (c1_angle),
    .tag      (c1_tag)
  );

  assign c1_z     = c1_tag[TAG1_W-1 -: C];
  assign c1_flags = c2s_pkg::c2s_flags_t'(c1_tag[FLAG_W-1:0]);
  assign z_ext    = ZP_W'(c1_z);
  assign gain_ext = ZP_W'(c2s_pkg::GAIN_Q30);

  // Scale z by the CORDIC gain; wrap and half-round the azimuth in one add
  always_ff @(posedge clk) begin
    if (rst) begin
      m1_vld <= 1'b0;
    end else begin
      m1_vld <= c1_done;
    end
  end

  always_ff @(posedge clk) begin
    m1_zprod <= z_ext * gain_ext;
    if (c1_angle[ACC_W-1]) begin
      m1_az_sum <= c1_angle + c2s_pkg::ANGLE_360 + HALF;
    end else begin
      m1_az_sum <= c1_angle + HALF;
    end
    m1_mag   <= c1_mag;
    m1_flags <= c1_flags;
  end

  // Drop fraction bits, fold 360 back to 0, round the scaled z
  assign az_rnd  = m1_az_sum >> SH;
  assign az_wrap = (az_rnd >= AZ_FULL) ? (az_rnd - AZ_FULL) : az_rnd;
  assign zk_sum  = m1_zprod + ZP_W'(32);

  always_ff @(posedge clk) begin
    if (rst) begin
      m2_vld <= 1'b0;
    end else begin
      m2_vld <= m1_vld;
    end
  end

  always_ff @(posedge clk) begin
    m2_zk    <= zk_sum[ZP_W-1:6];
    m2_az    <= az_wrap[AZ_W-1:0];
    m2_mag   <= m1_mag;
    m2_flags <= m1_flags;
  end

  // Pass two: polar angle of (z, xy magnitude)
  c2s_cordic #(
    .STAGES (N),
    .DATA_W (DW2),
    .TAG_W  (TAG2_W)
  ) u_pass_rz (
    .clk      (clk),
    .rst      (rst),
    .load     (m2_vld),
    .a_init   ({{(DW2 - ZK_W){m2_zk[ZK_W-1]}}, m2_zk}),
    .b_init   ({m2_mag[DW1-1], m2_mag}),
    .tag_init ({m2_az, m2_flags}),
    .done     (c2_done),
    .mag      (c2_mag),
    .angle    (c2_angle),
    .tag      (c2_tag)
  );

  assign c2_flags = c2s_pkg::c2s_flags_t'(c2_tag[FLAG_W-1:0]);

  // Clamp polar into 0..180 degrees and round it
  always_comb begin
    if (c2_angle[ACC_W-1]) begin
      po_clamp = '0;
    end else if (c2_angle > c2s_pkg::ANGLE_180) begin
      po_clamp = c2s_pkg::ANGLE_180;
    end else begin
      po_clamp = c2_angle;
    end
  end

  assign po_rnd = (po_clamp + HALF) >> SH;

  // Final stage: apply the axis and origin cases
  always_ff @(posedge clk) begin
    if (rst) begin
      f_vld <= 1'b0;
    end else begin
      f_vld <= c2_done;
    end
  end

  always_ff @(posedge clk) begin
    f_az <= c2_flags.xy_zero ? '0 : c2_tag[TAG2_W-1 -: AZ_W];
    f_po <= c2_flags.all_zero ? '0 : po_rnd[PO_W-1:0];
  end

  // Radius path
  c2s_radius #(
    .COORD_BITS (C)
  ) u_radius (
    .clk     (clk),
    .coord_x (coord_x),
    .coord_y (coord_y),
    .coord_z (coord_z),
    .radius  (rad_raw)
  );

  // Pad the shorter path so all fields meet at LAT
  if (RAD_DLY > 0) begin : g_rad_dly
    logic [C-1:0] rad_pipe [RAD_DLY];
    always_ff @(posedge clk) begin
      rad_pipe[0] <= rad_raw;
      for (int i = 1; i < RAD_DLY; i++) begin
        rad_pipe[i] <= rad_pipe[i-1];
      end
    end
    assign radius = rad_pipe[RAD_DLY-1];
  end else begin : g_rad_direct
    assign radius = rad_raw;
  end

  if (ANG_DLY > 0) begin : g_ang_dly
    logic [ANG_DLY-1:0] vld_pipe;
    logic [AZ_W-1:0]    az_pipe [ANG_DLY];
    logic [PO_W-1:0]    po_pipe [ANG_DLY];
    always_ff @(posedge clk) begin
      if (rst) begin
        vld_pipe <= '0;
      end else begin
        vld_pipe[0] <= f_vld;
        for (int i = 1; i < ANG_DLY; i++) begin
          vld_pipe[i] <= vld_pipe[i-1];
        end
      end
    end
    always_ff @(posedge clk) begin
      az_pipe[0] <= f_az;
      po_pipe[0] <= f_po;
      for (int i = 1; i < ANG_DLY; i++) begin
        az_pipe[i] <= az_pipe[i-1];
        po_pipe[i] <= po_pipe[i-1];
      end
    end
    assign done    = vld_pipe[ANG_DLY-1];
    assign azimuth = az_pipe[ANG_DLY-1];
    assign polar   = po_pipe[ANG_DLY-1];
  end else begin : g_ang_direct
    assign done    = f_vld;
    assign azimuth = f_az;
    assign polar   = f_po;
  end

`ifndef ASSERT_OFF
  // Every start beat yields a matching result
  a_start_to_done: assert property (@(posedge clk) disable iff (rst)
    start |-> ##LAT done)
    else $error("result missing LAT cycles after start");

  // No result without a matching start beat
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, LAT))
    else $error("result without matching start");

  // Zero radius only for the origin, which forces both angles to zero
  a_origin_zero: assert property (@(posedge clk) disable iff (rst)
    done && (radius == '0) |-> (azimuth == '0) && (polar == '0))
    else $error("origin gave nonzero angle");

  // A point on the z axis has zero azimuth
  a_axis_azimuth: assert property (@(posedge clk) disable iff (rst)
    done && $past(start && (coord_x == '0) && (coord_y == '0), LAT) |-> azimuth == '0)
    else $error("z-axis point gave nonzero azimuth");
`endif

endmodule

@@ rtl/c2s_cordic.sv @@
// ----------------------------------------------------------------------------
// c2s_cordic
// Unrolled vectoring CORDIC. One register stage folds the vector into the
// right half plane, then one register stage per micro-rotation drives b to
// zero while the angle accumulates. A side tag rides along with each beat.
// ----------------------------------------------------------------------------
module c2s_cordic #(
  parameter int STAGES = 18,
  parameter int DATA_W = 42,
  parameter int TAG_W  = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               load,
  input  logic signed [DATA_W-1:0]           a_init,
  input  logic signed [DATA_W-1:0]           b_init,
  input  logic        [TAG_W-1:0]            tag_init,
  output logic                               done,
  output logic signed [DATA_W-1:0]           mag,
  output logic signed [c2s_pkg::ACC_W-1:0]   angle,
  output logic        [TAG_W-1:0]            tag
);

  logic        [STAGES:0]           vld_q;
  logic signed [DATA_W-1:0]         a_q   [STAGES+1];
  logic signed [DATA_W-1:0]         b_q   [STAGES+1];
  logic signed [c2s_pkg::ACC_W-1:0] ang_q [STAGES+1];
  logic        [TAG_W-1:0]          tag_q [STAGES+1];

  // Advance valid bits with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[STAGES-1:0], load};
    end
  end

  // Fold into the right half plane, then rotate once per stage
  always_ff @(posedge clk) begin
    if (a_init[DATA_W-1]) begin
      a_q[0]   <= -a_init;
      b_q[0]   <= -b_init;
      ang_q[0] <= c2s_pkg::ANGLE_180;
    end else begin
      a_q[0]   <= a_init;
      b_q[0]   <= b_init;
      ang_q[0] <= '0;
    end
    tag_q[0] <= tag_init;

    for (int i = 0; i < STAGES; i++) begin
      if (!b_q[i][DATA_W-1]) begin
        a_q[i+1]   <= a_q[i] + (b_q[i] >>> i);
        b_q[i+1]   <= b_q[i] - (a_q[i] >>> i);
        ang_q[i+1] <= ang_q[i] + c2s_pkg::ATAN_DEG[i];
      end else begin
        a_q[i+1]   <= a_q[i] - (b_q[i] >>> i);
        b_q[i+1]   <= b_q[i] + (a_q[i] >>> i);
        ang_q[i+1] <= ang_q[i] - c2s_pkg::ATAN_DEG[i];
      end
      tag_q[i+1] <= tag_q[i];
    end
  end

  assign done  = vld_q[STAGES];
  assign mag   = a_q[STAGES];
  assign angle = ang_q[STAGES];
  assign tag   = tag_q[STAGES];

endmodule

@@ rtl/c2s_radius.sv @@
// ----------------------------------------------------------------------------
// c2s_radius
// Rounded Euclidean length of a point: squares, a three-way sum, then one
// register stage per root bit of a digit-by-digit square root, and a final
// round-to-nearest stage.
// ----------------------------------------------------------------------------
module c2s_radius #(
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic signed [COORD_BITS-1:0] coord_x,
  input  logic signed [COORD_BITS-1:0] coord_y,
  input  logic signed [COORD_BITS-1:0] coord_z,
  output logic        [COORD_BITS-1:0] radius
);

  localparam int C  = COORD_BITS;
  localparam int PW = 2 * C;   // sum of squares
  localparam int RW = C + 2;   // partial remainder

  logic signed [PW-1:0] prod_x, prod_y, prod_z;
  logic [PW-2:0]        sq_x, sq_y, sq_z;
  logic [PW-1:0]        sum_q;
  logic [RW-1:0]        rem_q  [C];
  logic [C-1:0]         root_q [C];
  logic [PW-1:0]        sv_q   [C-1];
  logic [C-1:0]         radius_q;

  assign prod_x = PW'(coord_x) * PW'(coord_x);
  assign prod_y = PW'(coord_y) * PW'(coord_y);
  assign prod_z = PW'(coord_z) * PW'(coord_z);

  // Register squares, then their sum
  always_ff @(posedge clk) begin
    sq_x  <= prod_x[PW-2:0];
    sq_y  <= prod_y[PW-2:0];
    sq_z  <= prod_z[PW-2:0];
    sum_q <= PW'(sq_x) + PW'(sq_y) + PW'(sq_z);
  end

  // Resolve one root bit per stage, two radicand bits at a time
  always_ff @(posedge clk) begin
    logic [RW-1:0] rem_in;
    logic [RW-1:0] rem_t;
    logic [RW-1:0] trial;
    logic [C-1:0]  root_in;
    logic [PW-1:0] sv_in;
    for (int k = 0; k < C; k++) begin
      if (k == 0) begin
        rem_in  = '0;
        root_in = '0;
        sv_in   = sum_q;
      end else begin
        rem_in  = rem_q[k-1];
        root_in = root_q[k-1];
        sv_in   = sv_q[k-1];
      end
      rem_t = {rem_in[C-1:0], sv_in[PW-1:PW-2]};
      trial = {root_in, 2'b01};
      if (rem_t >= trial) begin
        rem_q[k]  <= rem_t - trial;
        root_q[k] <= {root_in[C-2:0], 1'b1};
      end else begin
        rem_q[k]  <= rem_t;
        root_q[k] <= {root_in[C-2:0], 1'b0};
      end
      if (k < C - 1) begin
        sv_q[k] <= {sv_in[PW-3:0], 2'b00};
      end
    end
  end

  // Round up when the remainder exceeds the root
  always_ff @(posedge clk) begin
    if (rem_q[C-1] > RW'(root_q[C-1])) begin
      radius_q <= root_q[C-1] + C'(1);
    end else begin
      radius_q <= root_q[C-1];
    end
  end

  assign radius = radius_q;

endmodule
